[src/rsps_pkg.sv]
// Package: shared types, constants and codes for the record stack.
`timescale 1ns / 1ps
package rsps_pkg;
  localparam int Depth = 32;
  localparam int AddrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam int RevW = 35;
  localparam logic [RevW-1:0] RevMax = {RevW{1'b1}};

  typedef enum logic [2:0] {
    ACT_PUSH = 3'd0, ACT_POP = 3'd1, ACT_SORT = 3'd2, ACT_TOTAL = 3'd3, ACT_DUMP = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] dishes_count;
    logic [15:0] sold_count;
    logic [19:0] price_cents;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [15:0]     out_dishes;
    logic [15:0]     out_sold;
    logic [19:0]     out_price;
    logic [RevW-1:0] revenue_total;
    logic            last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [15:0] dishes;
    logic [15:0] sold;
    logic [19:0] price;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SORT_RD_KEY, S_SORT_KEY, S_SORT_RD, S_SORT_CMP, S_SORT_PUT,
    S_TOT_RD, S_TOT_MUL, S_TOT_DIV, S_TOT_ACC, S_TOT_OUT,
    S_DUMP_RD, S_DUMP_OUT
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;    // take the input transaction
    logic do_push;
    logic do_pop;
    logic out_simple; // strobe a single status result
    logic i_init;     // i <= 1
    logic i_inc;
    logic rd_i;       // read store[i]
    logic key_load;   // key <= read data, j <= i
    logic rd_jm1;     // read store[j-1]
    logic shift_wr;   // store[j] <= read data, j--
    logic key_wr;     // store[j] <= key
    logic tot_init;
    logic mul;
    logic divide;
    logic acc;
    logic out_total;
    logic dump_init;  // i <= count
    logic rd_top;     // read store[i-1]
    logic out_dump;   // emit read record, i--
  } ctl_t;

  typedef struct packed {
    logic [2:0] action;
    logic       empty;
    logic       full;
    logic       i_done;   // i >= count
    logic       j_zero;
    logic       less;     // store[j-1].price < key.price
    logic       i_one;    // dump: this is the last record
  } sts_t;
endpackage

[src/record_stack_with_price_sort_top.sv]
// Top level: record stack with price sort.
// One transaction is taken when start is high and busy low; busy is high from
// the next cycle until the action is done. Push and pop hold busy only for
// the decode slot, and their result shows in the cycle busy falls. Sort
// reports its status at once, then runs an insertion sort through one store
// port: for each record after the first it reads that record as key, then
// reads and compares the records below it, moving up each of lower price,
// and writes the key into the gap. Total reads, multiplies, divides by 100
// and adds each record in turn, then gives the sum; dump reads and gives
// each record in turn, top first. Each result shows on out_strobe for one
// cycle and cannot be held off. Action codes five to seven are not taken.
`timescale 1ns / 1ps
module record_stack_with_price_sort_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rsps_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output rsps_pkg::out_item_t out_item
);
  rsps_pkg::ctl_t ctl;
  rsps_pkg::sts_t sts;

  rsps_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_action(in_item.action),
    .sts(sts), .busy(busy), .ctl(ctl)
  );

  rsps_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .ctl(ctl), .sts(sts),
    .out_strobe(out_strobe), .out_item(out_item)
  );
endmodule

[src/rsps_dp.sv]
// Datapath: record store, counters, revenue multiply/divide and output register.
`timescale 1ns / 1ps
module rsps_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  rsps_pkg::in_item_t  in_item,
  input  rsps_pkg::ctl_t      ctl,
  output rsps_pkg::sts_t      sts,
  output logic                out_strobe,
  output rsps_pkg::out_item_t out_item
);
  rsps_pkg::rec_t mem [rsps_pkg::Depth];
  rsps_pkg::rec_t rd_r, key_r;
  rsps_pkg::in_item_t cmd_r;
  logic [rsps_pkg::CntW-1:0] cnt_r, i_r, j_r;
  logic [35:0] prod_r;
  logic [29:0] quo_r;
  logic [rsps_pkg::RevW-1:0] sum_r;
  logic [rsps_pkg::RevW:0] sum_nxt;
  logic [rsps_pkg::CntW-1:0] jm1, im1;
  logic [65:0] recip;
  logic [35:0] rem;
  logic [29:0] qfix;
  logic strobe_r;
  rsps_pkg::out_item_t out_r, out_nxt;

  assign jm1 = j_r - 1'b1;
  assign im1 = i_r - 1'b1;

  // divide by 100: registered reciprocal estimate (floor or one below),
  // correction on the next cycle while accumulating
  assign recip = prod_r * 30'd687194767;  // ~2^36/100

  always_comb begin
    rem = prod_r - {6'd0, quo_r} * 36'd100;
    qfix = (rem >= 36'd100) ? quo_r + 30'd1 : quo_r;
  end

  assign sum_nxt = {1'b0, sum_r} + {{(rsps_pkg::RevW - 29){1'b0}}, qfix};

  always_ff @(posedge clk) begin
    if (ctl.capture) cmd_r <= in_item;
    if (ctl.do_push) mem[cnt_r[rsps_pkg::AddrW-1:0]] <=
        '{dishes: cmd_r.dishes_count, sold: cmd_r.sold_count, price: cmd_r.price_cents};
    if (ctl.rd_i) rd_r <= mem[i_r[rsps_pkg::AddrW-1:0]];
    if (ctl.rd_jm1) rd_r <= mem[jm1[rsps_pkg::AddrW-1:0]];
    if (ctl.rd_top) rd_r <= mem[im1[rsps_pkg::AddrW-1:0]];
    if (ctl.key_load) key_r <= rd_r;
    if (ctl.shift_wr) mem[j_r[rsps_pkg::AddrW-1:0]] <= rd_r;
    if (ctl.key_wr) mem[j_r[rsps_pkg::AddrW-1:0]] <= key_r;
    if (ctl.mul) prod_r <= {16'd0, rd_r.price} * {20'd0, rd_r.sold};
    if (ctl.divide) quo_r <= recip[65:36];
  end

  always_comb begin
    out_nxt = out_r;
    if (ctl.out_simple) begin
      out_nxt = '0;
      out_nxt.last_of_run = 1'b1;
      if (cmd_r.action == rsps_pkg::ACT_PUSH && cnt_r == rsps_pkg::CntW'(rsps_pkg::Depth))
        out_nxt.status = rsps_pkg::ST_FULL;
      else if (cmd_r.action != rsps_pkg::ACT_PUSH && cnt_r == '0)
        out_nxt.status = rsps_pkg::ST_EMPTY;
    end
    if (ctl.out_total) begin
      out_nxt = '0;
      out_nxt.revenue_total = sum_r;
      out_nxt.last_of_run = 1'b1;
    end
    if (ctl.out_dump) begin
      out_nxt = '0;
      out_nxt.out_dishes = rd_r.dishes;
      out_nxt.out_sold = rd_r.sold;
      out_nxt.out_price = rd_r.price;
      out_nxt.last_of_run = (i_r == {{(rsps_pkg::CntW-1){1'b0}}, 1'b1});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      i_r <= '0;
      j_r <= '0;
      sum_r <= '0;
      strobe_r <= 1'b0;
      out_r <= '0;
    end else begin
      strobe_r <= ctl.out_simple | ctl.out_total | ctl.out_dump;
      out_r <= out_nxt;
      if (ctl.do_push) cnt_r <= cnt_r + 1'b1;
      if (ctl.do_pop) cnt_r <= cnt_r - 1'b1;
      if (ctl.i_init) i_r <= {{(rsps_pkg::CntW-1){1'b0}}, 1'b1};
      if (ctl.tot_init) i_r <= '0;
      if (ctl.i_inc) i_r <= i_r + 1'b1;
      if (ctl.dump_init) i_r <= cnt_r;
      if (ctl.out_dump) i_r <= im1;
      if (ctl.key_load) j_r <= i_r;
      if (ctl.shift_wr) j_r <= jm1;
      if (ctl.tot_init) sum_r <= '0;
      if (ctl.acc) sum_r <= sum_nxt[rsps_pkg::RevW] ? rsps_pkg::RevMax
                                                   : sum_nxt[rsps_pkg::RevW-1:0];
    end
  end

  assign sts.action = cmd_r.action;
  assign sts.empty = (cnt_r == '0);
  assign sts.full = (cnt_r == rsps_pkg::CntW'(rsps_pkg::Depth));
  assign sts.i_done = (i_r >= cnt_r);
  assign sts.j_zero = (j_r == '0);
  assign sts.less = (rd_r.price < key_r.price);
  assign sts.i_one = (i_r == {{(rsps_pkg::CntW-1){1'b0}}, 1'b1});
  assign out_strobe = strobe_r;
  assign out_item = out_r;
endmodule

[src/rsps_ctrl.sv]
// Controller: sequences push, pop, insertion sort, revenue total and dump.
`timescale 1ns / 1ps
module rsps_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [2:0]       in_action,
  input  rsps_pkg::sts_t   sts,
  output logic             busy,
  output rsps_pkg::ctl_t   ctl
);
  rsps_pkg::state_t state_r, state_nxt;
  logic go;
  // one-cycle decode slot after capture lives in S_IDLE via pend_r
  logic pend_r;

  assign go = start && !busy && (in_action <= 3'(rsps_pkg::ACT_DUMP));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rsps_pkg::S_IDLE;
      pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r <= go;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rsps_pkg::S_IDLE: if (pend_r) begin
        unique case (sts.action)
          3'(rsps_pkg::ACT_SORT):  if (!sts.empty) state_nxt = rsps_pkg::S_SORT_RD_KEY;
          3'(rsps_pkg::ACT_TOTAL): if (!sts.empty) state_nxt = rsps_pkg::S_TOT_RD;
          3'(rsps_pkg::ACT_DUMP):  if (!sts.empty) state_nxt = rsps_pkg::S_DUMP_RD;
          default: state_nxt = rsps_pkg::S_IDLE;
        endcase
      end
      rsps_pkg::S_SORT_RD_KEY: state_nxt = sts.i_done ? rsps_pkg::S_IDLE : rsps_pkg::S_SORT_KEY;
      rsps_pkg::S_SORT_KEY: state_nxt = rsps_pkg::S_SORT_RD;
      rsps_pkg::S_SORT_RD: state_nxt = sts.j_zero ? rsps_pkg::S_SORT_PUT : rsps_pkg::S_SORT_CMP;
      rsps_pkg::S_SORT_CMP: state_nxt = sts.less ? rsps_pkg::S_SORT_RD : rsps_pkg::S_SORT_PUT;
      rsps_pkg::S_SORT_PUT: state_nxt = rsps_pkg::S_SORT_RD_KEY;
      rsps_pkg::S_TOT_RD: state_nxt = sts.i_done ? rsps_pkg::S_TOT_OUT : rsps_pkg::S_TOT_MUL;
      rsps_pkg::S_TOT_MUL: state_nxt = rsps_pkg::S_TOT_DIV;
      rsps_pkg::S_TOT_DIV: state_nxt = rsps_pkg::S_TOT_ACC;
      rsps_pkg::S_TOT_ACC: state_nxt = rsps_pkg::S_TOT_RD;
      rsps_pkg::S_TOT_OUT: state_nxt = rsps_pkg::S_IDLE;
      rsps_pkg::S_DUMP_RD: state_nxt = rsps_pkg::S_DUMP_OUT;
      rsps_pkg::S_DUMP_OUT: state_nxt = sts.i_one ? rsps_pkg::S_IDLE : rsps_pkg::S_DUMP_RD;
      default: state_nxt = rsps_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    busy = (state_r != rsps_pkg::S_IDLE) || pend_r;
    unique case (state_r)
      rsps_pkg::S_IDLE: if (pend_r) begin
        unique case (sts.action)
          3'(rsps_pkg::ACT_PUSH): begin
            ctl.out_simple = 1'b1;
            ctl.do_push = !sts.full;
          end
          3'(rsps_pkg::ACT_POP): begin
            ctl.out_simple = 1'b1;
            ctl.do_pop = !sts.empty;
          end
          3'(rsps_pkg::ACT_SORT): begin
            ctl.out_simple = 1'b1;
            ctl.i_init = !sts.empty;
          end
          3'(rsps_pkg::ACT_TOTAL): begin
            ctl.out_simple = sts.empty;
            ctl.tot_init = !sts.empty;
          end
          default: begin
            ctl.out_simple = sts.empty;
            ctl.dump_init = !sts.empty;
          end
        endcase
      end
      rsps_pkg::S_SORT_RD_KEY: ctl.rd_i = !sts.i_done;
      rsps_pkg::S_SORT_KEY: ctl.key_load = 1'b1;
      rsps_pkg::S_SORT_RD: ctl.rd_jm1 = !sts.j_zero;
      rsps_pkg::S_SORT_CMP: ctl.shift_wr = sts.less;
      rsps_pkg::S_SORT_PUT: begin
        ctl.key_wr = 1'b1;
        ctl.i_inc = 1'b1;
      end
      rsps_pkg::S_TOT_RD: ctl.rd_i = !sts.i_done;
      rsps_pkg::S_TOT_MUL: ctl.mul = 1'b1;
      rsps_pkg::S_TOT_DIV: begin
        ctl.divide = 1'b1;
        ctl.i_inc = 1'b1;
      end
      rsps_pkg::S_TOT_ACC: ctl.acc = 1'b1;
      rsps_pkg::S_TOT_OUT: ctl.out_total = 1'b1;
      rsps_pkg::S_DUMP_RD: ctl.rd_top = 1'b1;
      rsps_pkg::S_DUMP_OUT: ctl.out_dump = 1'b1;
      default: ctl = '0;
    endcase
    ctl.capture = go;
  end
endmodule

[dv/record_stack_checker.sv]
// Checker: watches both channels, predicts results and compares them.
`timescale 1ns / 1ps
module record_stack_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  rsps_pkg::in_item_t  in_item,
  input  logic                out_strobe,
  input  rsps_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending_count,
  output int                  results_seen
);
  rsps_pkg::rec_t      shadow_store [rsps_pkg::Depth];
  int                  shadow_count;
  rsps_pkg::out_item_t expected_results [$];

  task automatic report_mismatch(input string what);
    $display("%0t MISMATCH: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic rsps_pkg::out_item_t make_result(logic [1:0] st, rsps_pkg::rec_t r,
                                                      logic [rsps_pkg::RevW-1:0] rev,
                                                      logic last);
    rsps_pkg::out_item_t o;
    o.status = st;
    o.out_dishes = r.dishes;
    o.out_sold = r.sold;
    o.out_price = r.price;
    o.revenue_total = rev;
    o.last_of_run = last;
    return o;
  endfunction

  // Insertion sort, descending by index, so top-down ascending and stable.
  task automatic sort_by_price();
    rsps_pkg::rec_t key;
    int j;
    for (int i = 1; i < shadow_count; i++) begin
      key = shadow_store[i];
      j = i;
      while (j > 0 && shadow_store[j-1].price < key.price) begin
        shadow_store[j] = shadow_store[j-1];
        j--;
      end
      shadow_store[j] = key;
    end
  endtask

  task automatic predict_action(rsps_pkg::in_item_t it);
    rsps_pkg::rec_t none;
    rsps_pkg::rec_t r;
    logic [63:0] sum;
    none = '0;
    case (it.action)
      rsps_pkg::ACT_PUSH: begin
        if (shadow_count >= rsps_pkg::Depth) begin
          expected_results.push_back(make_result(rsps_pkg::ST_FULL, none, '0, 1'b1));
        end else begin
          r.dishes = it.dishes_count;
          r.sold = it.sold_count;
          r.price = it.price_cents;
          shadow_store[shadow_count] = r;
          shadow_count++;
          expected_results.push_back(make_result(rsps_pkg::ST_OK, none, '0, 1'b1));
        end
      end
      rsps_pkg::ACT_POP, rsps_pkg::ACT_SORT, rsps_pkg::ACT_TOTAL: begin
        if (shadow_count == 0) begin
          expected_results.push_back(make_result(rsps_pkg::ST_EMPTY, none, '0, 1'b1));
        end else if (it.action == rsps_pkg::ACT_POP) begin
          shadow_count--;
          expected_results.push_back(make_result(rsps_pkg::ST_OK, none, '0, 1'b1));
        end else if (it.action == rsps_pkg::ACT_SORT) begin
          sort_by_price();
          expected_results.push_back(make_result(rsps_pkg::ST_OK, none, '0, 1'b1));
        end else begin
          sum = 0;
          for (int i = 0; i < shadow_count; i++) begin
            sum += (64'(shadow_store[i].price) * 64'(shadow_store[i].sold)) / 100;
            if (sum > 64'(rsps_pkg::RevMax)) sum = 64'(rsps_pkg::RevMax);
          end
          expected_results.push_back(make_result(rsps_pkg::ST_OK, none,
                                                 sum[rsps_pkg::RevW-1:0], 1'b1));
        end
      end
      rsps_pkg::ACT_DUMP: begin
        if (shadow_count == 0) begin
          expected_results.push_back(make_result(rsps_pkg::ST_EMPTY, none, '0, 1'b1));
        end else begin
          for (int i = shadow_count; i > 0; i--)
            expected_results.push_back(make_result(rsps_pkg::ST_OK, shadow_store[i-1], '0,
                                                   logic'(i == 1)));
        end
      end
      default: ;  // unused codes are ignored
    endcase
  endtask

  always @(posedge clk) begin
    rsps_pkg::out_item_t want;
    if (!rst_n) begin
      shadow_count = 0;
      expected_results.delete();
    end else begin
      if (out_strobe) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (out_item.status !== want.status)
            report_mismatch($sformatf("status %0d want %0d", out_item.status, want.status));
          if (out_item.out_dishes !== want.out_dishes)
            report_mismatch($sformatf("dishes %0d want %0d", out_item.out_dishes,
                                      want.out_dishes));
          if (out_item.out_sold !== want.out_sold)
            report_mismatch($sformatf("sold %0d want %0d", out_item.out_sold,
                                      want.out_sold));
          if (out_item.out_price !== want.out_price)
            report_mismatch($sformatf("price %0d want %0d", out_item.out_price,
                                      want.out_price));
          if (out_item.revenue_total !== want.revenue_total)
            report_mismatch($sformatf("revenue %0d want %0d", out_item.revenue_total,
                                      want.revenue_total));
          if (out_item.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last %0b want %0b", out_item.last_of_run,
                                      want.last_of_run));
        end
      end
      if (start && !busy) predict_action(in_item);
    end
    pending_count = expected_results.size();
  end

  initial begin
    fail_count = 0;
    results_seen = 0;
    pending_count = 0;
  end
endmodule

[dv/testbench.sv]
// Testbench top: stimulus, clock, reset and verdict for the record stack.
`timescale 1ns / 1ps
module testbench;
  localparam int CycleLimit = 1000000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  rsps_pkg::in_item_t  in_item;
  logic                out_strobe;
  rsps_pkg::out_item_t out_item;
  int                  fail_count;
  int                  pending_count;
  int                  results_seen;
  int                  cycle_count;
  int                  items_sent;
  int                  actions_sent [8];

  record_stack_with_price_sort_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item)
  );

  record_stack_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .fail_count(fail_count),
    .pending_count(pending_count), .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench failed");
      $finish;
    end
  end

  // Holds one transaction on the port until accepted, then may idle a while.
  task automatic send_item(logic [2:0] act, logic [15:0] d, logic [15:0] s,
                           logic [19:0] p);
    int gap;
    in_item.action = act;
    in_item.dishes_count = d;
    in_item.sold_count = s;
    in_item.price_cents = p;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    actions_sent[act]++;
    @(negedge clk);
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
          ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic push_random(int mode);
    logic [19:0] p;
    case (mode)
      0: p = 20'($urandom_range(0, 20));
      1: p = 20'hFFFFF;
      default: p = 20'($urandom);
    endcase
    send_item(rsps_pkg::ACT_PUSH, 16'($urandom), 16'($urandom), p);
  endtask

  initial begin
    logic [2:0] act;
    int roll;
    cycle_count = 0;
    items_sent = 0;
    foreach (actions_sent[k]) actions_sent[k] = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty cases, extremes, equal prices, full store, large totals
    send_item(rsps_pkg::ACT_POP, '0, '0, '0);
    send_item(rsps_pkg::ACT_SORT, '0, '0, '0);
    send_item(rsps_pkg::ACT_TOTAL, '0, '0, '0);
    send_item(rsps_pkg::ACT_DUMP, '0, '0, '0);
    send_item(3'd5, '1, '1, '1);
    send_item(3'd7, '0, '0, '0);
    send_item(rsps_pkg::ACT_PUSH, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
    send_item(rsps_pkg::ACT_PUSH, 16'h0000, 16'h0000, 20'h00000);
    send_item(rsps_pkg::ACT_PUSH, 16'h1234, 16'd99, 20'd150);
    send_item(rsps_pkg::ACT_PUSH, 16'h4321, 16'd7, 20'd150);
    send_item(3'd6, '1, '0, '1);
    send_item(rsps_pkg::ACT_SORT, '0, '0, '0);
    send_item(rsps_pkg::ACT_DUMP, '0, '0, '0);
    send_item(rsps_pkg::ACT_TOTAL, '0, '0, '0);
    send_item(rsps_pkg::ACT_POP, '0, '0, '0);
    for (int k = 0; k < 31; k++) push_random(1);  // fills, then overflows
    send_item(rsps_pkg::ACT_TOTAL, '0, '0, '0);     // large sum
    send_item(rsps_pkg::ACT_SORT, '0, '0, '0);
    send_item(rsps_pkg::ACT_DUMP, '0, '0, '0);
    for (int k = 0; k < 32; k++) send_item(rsps_pkg::ACT_POP, '0, '0, '0);

    // random: a push-heavy mix so the store fills and drains
    for (int k = 0; k < 280; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) act = rsps_pkg::ACT_PUSH;
      else if (roll < 70) act = rsps_pkg::ACT_POP;
      else if (roll < 80) act = rsps_pkg::ACT_SORT;
      else if (roll < 88) act = rsps_pkg::ACT_TOTAL;
      else if (roll < 96) act = rsps_pkg::ACT_DUMP;
      else act = 3'($urandom_range(5, 7));
      if (act == rsps_pkg::ACT_PUSH) push_random($urandom_range(0, 3));
      else send_item(act, 16'($urandom), 16'($urandom), 20'($urandom));
    end
    start <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d transactions (push %0d pop %0d sort %0d total %0d dump %0d)",
             items_sent, actions_sent[0], actions_sent[1], actions_sent[2],
             actions_sent[3], actions_sent[4]);
    $display("checked %0d results in %0d cycles", results_seen, cycle_count);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

[sim.f]
src/rsps_pkg.sv
src/rsps_dp.sv
src/rsps_ctrl.sv
src/record_stack_with_price_sort_top.sv
dv/record_stack_checker.sv
dv/testbench.sv
